// ===== rtl/core/ntt_alu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constant helpers for the NTT coefficient ALU.
// Used by ntt_alu_mont, ntt_alu_lane and ntt_coefficient_alu; no dependencies.
package ntt_alu_pkg;

  // Default modulus of the ring.
  localparam int unsigned DEFAULT_MODULUS = 7681;

  // Coefficient lanes per beat and pipeline depth before the output register.
  localparam int NUM_LANES  = 4;
  localparam int NUM_STAGES = 6;

  // Action codes on the input channel.
  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_SUB     = 3'd1,
    ACT_BARRETT = 3'd2,
    ACT_TOMONT  = 3'd3,
    ACT_BASEMUL = 3'd4
  } action_t;

  // What a lane does with its operands, and how the merge stage picks its result.
  typedef enum logic [2:0] {
    LM_ZERO    = 3'd0,
    LM_ADD     = 3'd1,
    LM_SUB     = 3'd2,
    LM_BARRETT = 3'd3,
    LM_MONT    = 3'd4,
    LM_PAIR    = 3'd5,
    LM_TWIST   = 3'd6
  } lane_mode_t;

  // Operands steered into one lane.
  typedef struct packed {
    lane_mode_t         mode;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] w;
  } lane_in_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    lane_mode_t         mode;
    logic signed [15:0] r0;
    logic signed [15:0] r1;
    logic signed [15:0] r2;
    logic signed [15:0] alt;
  } lane_out_t;

  // Inverse of q modulo 2^16 by five Newton steps, all arithmetic mod 2^16.
  function automatic logic [15:0] qinv16(input logic [15:0] q);
    logic [15:0] x;
    x = q;
    for (int k = 0; k < 5; k++) begin
      x = x * (16'd2 - q * x);
    end
    return x;
  endfunction

endpackage

// ===== rtl/core/ntt_coefficient_alu.sv =====
`timescale 1ns / 1ps
// Top level of the NTT coefficient ALU: operand steering, four lanes,
// merge stage and output register. Uses ntt_alu_pkg and ntt_alu_lane.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------------------
//   input   | in_valid  | in_ready  | action, a_0..a_3, b_0..b_3, zeta
//   output  | out_valid | out_ready | c_0..c_3
//
// One beat is accepted per cycle while in_ready is high; each result passes through
// the pipeline stages and the output register, set by the two chained three-stage Montgomery products.
// Reset clears only the stage valid bits and out_valid.
// A stall at the output fills pipeline bubbles first; in_ready stays high
// as long as some stage is empty or moving.
module ntt_coefficient_alu #(
  parameter int unsigned MODULUS = ntt_alu_pkg::DEFAULT_MODULUS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [15:0] a_0,
  input  logic signed [15:0] a_1,
  input  logic signed [15:0] a_2,
  input  logic signed [15:0] a_3,
  input  logic signed [15:0] b_0,
  input  logic signed [15:0] b_1,
  input  logic signed [15:0] b_2,
  input  logic signed [15:0] b_3,
  input  logic signed [15:0] zeta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] c_0,
  output logic signed [15:0] c_1,
  output logic signed [15:0] c_2,
  output logic signed [15:0] c_3
);
  import ntt_alu_pkg::*;

  localparam logic signed [15:0] MontF = 16'((64'd1 << 32) % MODULUS);

  logic signed [15:0] a_arr  [NUM_LANES];
  logic signed [15:0] b_arr  [NUM_LANES];
  logic signed [15:0] c_next [NUM_LANES];
  logic signed [15:0] nzeta;
  lane_in_t           lane_op  [NUM_LANES];
  lane_out_t          lane_res [NUM_LANES];
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] ld;
  logic                  ld_out;

  assign a_arr[0] = a_0;
  assign a_arr[1] = a_1;
  assign a_arr[2] = a_2;
  assign a_arr[3] = a_3;
  assign b_arr[0] = b_0;
  assign b_arr[1] = b_1;
  assign b_arr[2] = b_2;
  assign b_arr[3] = b_3;
  assign nzeta    = 16'sd0 - zeta;

  // Load enables: a stage takes new data when it is empty or its content moves on.
  assign ld_out = ~out_valid | out_ready;
  always_comb begin
    ld[NUM_STAGES-1] = ~v[NUM_STAGES-1] | ld_out;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = ~v[k] | ld[k+1];
    end
  end
  assign in_ready = ld[0];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (ld_out) begin
        out_valid <= v[NUM_STAGES-1];
      end
    end
  end

  // Operand steering and one lane per result coefficient.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam int Base = (i / 2) * 2;

    always_comb begin
      lane_op[i].mode = LM_ZERO;
      lane_op[i].x0   = a_arr[i];
      lane_op[i].y0   = b_arr[i];
      lane_op[i].x1   = a_arr[i];
      lane_op[i].y1   = b_arr[i];
      lane_op[i].w    = zeta;
      unique case (action_t'(action))
        ACT_ADD:     lane_op[i].mode = LM_ADD;
        ACT_SUB:     lane_op[i].mode = LM_SUB;
        ACT_BARRETT: lane_op[i].mode = LM_BARRETT;
        ACT_TOMONT: begin
          lane_op[i].mode = LM_MONT;
          lane_op[i].y0   = MontF;
        end
        ACT_BASEMUL: begin
          lane_op[i].x0 = a_arr[Base];
          lane_op[i].x1 = a_arr[Base+1];
          if (i % 2 == 0) begin
            // Even result: a0*b0 plus (a1*b1)*zeta, zeta negated on the second pair.
            lane_op[i].mode = LM_TWIST;
            lane_op[i].y0   = b_arr[Base];
            lane_op[i].y1   = b_arr[Base+1];
            lane_op[i].w    = (Base == 0) ? zeta : nzeta;
          end else begin
            // Odd result: the cross products a0*b1 plus a1*b0.
            lane_op[i].mode = LM_PAIR;
            lane_op[i].y0   = b_arr[Base+1];
            lane_op[i].y1   = b_arr[Base];
          end
        end
        default: lane_op[i].mode = LM_ZERO;
      endcase
    end

    ntt_alu_lane #(.MODULUS(MODULUS)) u_lane (
      .clk (clk),
      .ld  (ld),
      .op  (lane_op[i]),
      .res (lane_res[i])
    );
  end

  // Merge stage: pick or sum each lane's partial results.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      unique case (lane_res[i].mode)
        LM_ADD, LM_SUB, LM_BARRETT: c_next[i] = lane_res[i].alt;
        LM_MONT:                    c_next[i] = lane_res[i].r0;
        LM_PAIR:                    c_next[i] = lane_res[i].r0 + lane_res[i].r1;
        LM_TWIST:                   c_next[i] = lane_res[i].r0 + lane_res[i].r2;
        default:                    c_next[i] = '0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ld_out) begin
      c_0 <= c_next[0];
      c_1 <= c_next[1];
      c_2 <= c_next[2];
      c_3 <= c_next[3];
    end
  end

  // A free output side never blocks the input side.
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // A finished beat moves into an empty output register on the next edge.
  assert property (@(posedge clk) disable iff (rst)
    (v[NUM_STAGES-1] && !out_valid) |=> out_valid)
    else $error("last stage did not drain into empty output register");

  // An accepted beat occupies the first stage.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> v[0])
    else $error("accepted beat lost at first stage");

endmodule

// ===== rtl/core/ntt_alu_mont.sv =====
`timescale 1ns / 1ps
// Three-stage pipelined Montgomery product with R = 2^16.
// Depends on ntt_alu_pkg for the modular inverse helper.
module ntt_alu_mont #(
  parameter int unsigned MODULUS = ntt_alu_pkg::DEFAULT_MODULUS
) (
  input  logic               clk,
  input  logic [2:0]         ld,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic signed [15:0] r
);
  import ntt_alu_pkg::*;

  localparam logic [15:0]        Qinv = qinv16(16'(MODULUS));
  localparam logic signed [15:0] Qs   = 16'(MODULUS);

  logic signed [31:0] p;
  logic [15:0]        t;
  logic signed [15:0] hi1;
  logic signed [15:0] hi2;
  logic signed [15:0] th;
  logic [31:0]        lo_prod;
  logic signed [31:0] tq;

  // Low half times q^-1, and the reduction term times q.
  assign lo_prod = 32'(p[15:0]) * 32'(Qinv);
  assign tq      = $signed(t) * Qs;

  // Full product, then the quotient estimate, then its multiple of q.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p <= x * y;
    end
    if (ld[1]) begin
      hi1 <= p[31:16];
      t   <= lo_prod[15:0];
    end
    if (ld[2]) begin
      hi2 <= hi1;
      th  <= tq[31:16];
    end
  end

  // High half minus the correction, wrapped to 16 bits.
  assign r = hi2 - th;

endmodule

// ===== rtl/core/ntt_alu_lane.sv =====
`timescale 1ns / 1ps
// One coefficient lane: two Montgomery products, a chained twist product,
// a Barrett path and add/sub, pipelined over six stages. Uses ntt_alu_pkg.
module ntt_alu_lane #(
  parameter int unsigned MODULUS = ntt_alu_pkg::DEFAULT_MODULUS
) (
  input  logic                                 clk,
  input  logic [ntt_alu_pkg::NUM_STAGES-1:0]   ld,
  input  ntt_alu_pkg::lane_in_t                op,
  output ntt_alu_pkg::lane_out_t               res
);
  import ntt_alu_pkg::*;

  localparam logic signed [15:0] BarrettV = 16'(((1 << 26) + MODULUS / 2) / MODULUS);
  localparam logic signed [15:0] Qs       = 16'(MODULUS);

  lane_mode_t         mode_s [NUM_STAGES];
  logic signed [15:0] alt_s  [NUM_STAGES];
  logic signed [15:0] w_s    [3];
  logic signed [15:0] a_s    [3];
  logic signed [15:0] r0_s   [3];
  logic signed [15:0] r1_s   [3];
  logic signed [31:0] bp;
  logic signed [5:0]  tb;
  logic signed [15:0] bq;
  logic signed [15:0] bsum;
  logic signed [21:0] bq_full;
  logic signed [15:0] m0_r;
  logic signed [15:0] m1_r;
  logic signed [15:0] m2_r;

  // Barrett rounding: high half plus one half of 2^10, wrapped.
  assign bsum    = bp[31:16] + 16'sd512;
  assign bq_full = tb * Qs;

  // Control and side-path delay line, plus the Barrett steps.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mode_s[0] <= op.mode;
      w_s[0]    <= op.w;
      a_s[0]    <= op.x0;
      bp        <= op.x0 * BarrettV;
      alt_s[0]  <= (op.mode == LM_SUB) ? op.x0 - op.y0 : op.x0 + op.y0;
    end
    if (ld[1]) begin
      w_s[1] <= w_s[0];
      a_s[1] <= a_s[0];
      tb     <= bsum[15:10];
    end
    if (ld[2]) begin
      w_s[2] <= w_s[1];
      a_s[2] <= a_s[1];
      bq     <= bq_full[15:0];
    end
    if (ld[3]) begin
      alt_s[3] <= (mode_s[2] == LM_BARRETT) ? a_s[2] - bq : alt_s[2];
      r0_s[0]  <= m0_r;
      r1_s[0]  <= m1_r;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ld[k]) begin
        mode_s[k] <= mode_s[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (ld[k]) begin
        alt_s[k] <= alt_s[k-1];
      end
    end
    for (int k = 4; k < NUM_STAGES; k++) begin
      if (ld[k]) begin
        alt_s[k]  <= alt_s[k-1];
        r0_s[k-3] <= r0_s[k-4];
        r1_s[k-3] <= r1_s[k-4];
      end
    end
  end

  // First-level products on the two operand pairs.
  ntt_alu_mont #(.MODULUS(MODULUS)) u_mont0 (
    .clk (clk),
    .ld  (ld[2:0]),
    .x   (op.x0),
    .y   (op.y0),
    .r   (m0_r)
  );

  ntt_alu_mont #(.MODULUS(MODULUS)) u_mont1 (
    .clk (clk),
    .ld  (ld[2:0]),
    .x   (op.x1),
    .y   (op.y1),
    .r   (m1_r)
  );

  // Second product of the odd pair by the twiddle.
  ntt_alu_mont #(.MODULUS(MODULUS)) u_mont2 (
    .clk (clk),
    .ld  (ld[5:3]),
    .x   (m1_r),
    .y   (w_s[2]),
    .r   (m2_r)
  );

  assign res.mode = mode_s[NUM_STAGES-1];
  assign res.r0   = r0_s[2];
  assign res.r1   = r1_s[2];
  assign res.r2   = m2_r;
  assign res.alt  = alt_s[NUM_STAGES-1];

endmodule
